@@ sv/monotonic_timebase_ns_assert.svh @@
// assertion macros used by the timebase top module
`ifndef MONOTONIC_TIMEBASE_NS_ASSERT_SVH
`define MONOTONIC_TIMEBASE_NS_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define MTNS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timebase check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define MTNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timebase check failed");

`endif

@@ sv/mtns_pkg.sv @@
// shared types and constants of the nanosecond timebase
package mtns_pkg;

  localparam int ValW  = 64;
  localparam int RateW = 34;
  localparam int ProdW = ValW + RateW;
  localparam int CntW  = $clog2(ValW + 1);

  localparam logic [RateW-1:0] NsPerSec = RateW'(1000000000);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CYC2NS = 2'd2,
    CMD_NS2CYC = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ENABLED    = 2'd0,
    CFG_TICK_HZ    = 2'd1,
    CFG_COUNTER_HZ = 2'd2,
    CFG_CYCLE_BASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_CHK,
    SC_DIV
  } sc_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT_MARK,
    ST_WAIT_NS,
    ST_CLAMP,
    ST_WAIT_DER,
    ST_WAIT_CONV,
    ST_DONE
  } top_state_e;

  typedef struct packed {
    logic start;
    logic skip_mul;
  } sc_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } sc_rsp_t;

endpackage

@@ sv/mtns_scale.sv @@
// bit-serial saturating floor(v * m / d): shift-add multiply (skipped on request) then restoring divide
module mtns_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mtns_pkg::sc_req_t             req_i,
  input  logic [mtns_pkg::ValW-1:0]     v_i,
  input  logic [mtns_pkg::RateW-1:0]    m_i,
  input  logic [mtns_pkg::RateW-1:0]    d_i,
  output mtns_pkg::sc_rsp_t             rsp_o,
  output logic [mtns_pkg::ValW-1:0]     quot_o,
  output logic [mtns_pkg::RateW-1:0]    rem_o
);

  mtns_pkg::sc_state_e             state_q, state_d;
  logic [mtns_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            done_q, done_d;
  logic                            sat_q, sat_d;
  logic [mtns_pkg::ProdW-1:0]      acc_q, acc_d;
  logic [mtns_pkg::ValW-1:0]       v_q, v_d;
  logic [mtns_pkg::RateW-1:0]      m_q, m_d;
  logic [mtns_pkg::RateW-1:0]      d_q, d_d;
  logic [mtns_pkg::RateW-1:0]      rem_q, rem_d;
  logic [mtns_pkg::RateW:0]        trial;
  logic [mtns_pkg::RateW:0]        diff;
  logic                            ge;

  // one divisor compare per cycle
  assign trial = {rem_q, acc_q[mtns_pkg::ValW-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  // sequencer: multiply one multiplier bit a cycle, then one quotient bit a cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    sat_d   = sat_q;
    acc_d   = acc_q;
    v_d     = v_q;
    m_d     = m_q;
    d_d     = d_q;
    rem_d   = rem_q;
    unique case (state_q)
      mtns_pkg::SC_IDLE: begin
        if (req_i.start) begin
          v_d   = v_i;
          m_d   = m_i;
          d_d   = d_i;
          sat_d = 1'b0;
          if (req_i.skip_mul) begin
            acc_d   = {{mtns_pkg::RateW{1'b0}}, v_i};
            state_d = mtns_pkg::SC_CHK;
          end else begin
            acc_d   = '0;
            cnt_d   = mtns_pkg::CntW'(mtns_pkg::RateW);
            state_d = mtns_pkg::SC_MUL;
          end
        end
      end
      mtns_pkg::SC_MUL: begin
        acc_d = {acc_q[mtns_pkg::ProdW-2:0], 1'b0}
              + (m_q[mtns_pkg::RateW-1] ? {{mtns_pkg::RateW{1'b0}}, v_q}
                                         : {mtns_pkg::ProdW{1'b0}});
        m_d   = {m_q[mtns_pkg::RateW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == mtns_pkg::CntW'(1)) begin
          state_d = mtns_pkg::SC_CHK;
        end
      end
      mtns_pkg::SC_CHK: begin
        // quotient reaches 2^64 exactly when the upper product part is at least d
        if (acc_q[mtns_pkg::ProdW-1:mtns_pkg::ValW] >= d_q) begin
          sat_d   = 1'b1;
          done_d  = 1'b1;
          state_d = mtns_pkg::SC_IDLE;
        end else begin
          rem_d   = acc_q[mtns_pkg::ProdW-1:mtns_pkg::ValW];
          cnt_d   = mtns_pkg::CntW'(mtns_pkg::ValW);
          state_d = mtns_pkg::SC_DIV;
        end
      end
      mtns_pkg::SC_DIV: begin
        rem_d = ge ? diff[mtns_pkg::RateW-1:0] : trial[mtns_pkg::RateW-1:0];
        acc_d[mtns_pkg::ValW-1:0] = {acc_q[mtns_pkg::ValW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == mtns_pkg::CntW'(1)) begin
          done_d  = 1'b1;
          state_d = mtns_pkg::SC_IDLE;
        end
      end
      default: state_d = mtns_pkg::SC_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtns_pkg::SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    acc_q <= acc_d;
    v_q   <= v_d;
    m_q   <= m_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign quot_o     = acc_q[mtns_pkg::ValW-1:0];
  assign rem_o      = rem_q;

endmodule

@@ sv/monotonic_timebase_ns.sv @@
// monotonic nanosecond timebase: tick count, clamped reads and rate conversions
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   in       | in_valid_i / in_stall_o    | command_i, cycle_count_i, operand_value_i
//   out      | out_valid_o / out_stall_i  | result_value_o, tick_count_o, second_mark_o
//   cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item at a time; the bit-serial scaler (34 multiply steps, one saturation
// check, 64 divide steps) sets the time from accept to out_valid_o; a tick skips
// the multiply, a conversion scales once and a read may scale twice.
// reset clears the tick count, last time and all configuration registers.
// a finished result waits in the output register; the next item is taken meanwhile.
module monotonic_timebase_ns (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [mtns_pkg::ValW-1:0]  cycle_count_i,
  input  logic [mtns_pkg::ValW-1:0]  operand_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mtns_pkg::ValW-1:0]  result_value_o,
  output logic [mtns_pkg::ValW-1:0]  tick_count_o,
  output logic                       second_mark_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [mtns_pkg::ValW-1:0]  cfg_data_i
);

`include "monotonic_timebase_ns_assert.svh"

  mtns_pkg::top_state_e            state_q, state_d;
  logic                            enabled_q;
  logic [29:0]                     tick_hz_q;
  logic [mtns_pkg::RateW-1:0]      counter_hz_q;
  logic [mtns_pkg::ValW-1:0]       cycle_base_q;
  logic [mtns_pkg::ValW-1:0]       tick_total_q, tick_total_d;
  logic [mtns_pkg::ValW-1:0]       last_ns_q, last_ns_d;
  mtns_pkg::cmd_e                  cmd_q;
  logic [mtns_pkg::ValW-1:0]       cyc_q, opv_q;
  logic [mtns_pkg::ValW-1:0]       res_q, res_d;
  logic                            mark_q, mark_d;
  logic                            out_valid_q, out_valid_d;
  logic [mtns_pkg::ValW-1:0]       result_value_q, tick_count_q;
  logic                            second_mark_q;
  logic                            in_acc, out_acc, out_load;
  logic                            sc_wait;

  mtns_pkg::sc_req_t               sc_req;
  mtns_pkg::sc_rsp_t               sc_rsp;
  logic [mtns_pkg::ValW-1:0]       sc_v, sc_quot, sc_val, ns_c;
  logic [mtns_pkg::RateW-1:0]      sc_m, sc_d, sc_rem, tick_hz_w, rate;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign in_stall_o  = state_q != mtns_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;

  assign tick_hz_w = {4'd0, tick_hz_q};
  assign rate      = (counter_hz_q != '0) ? counter_hz_q : tick_hz_w;
  assign sc_val    = sc_rsp.sat ? {mtns_pkg::ValW{1'b1}} : sc_quot;
  assign ns_c      = (res_q < last_ns_q) ? last_ns_q : res_q;
  assign out_load  = (state_q == mtns_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer is waiting on the scaler
  assign sc_wait = (state_q == mtns_pkg::ST_WAIT_MARK) || (state_q == mtns_pkg::ST_WAIT_NS) ||
                   (state_q == mtns_pkg::ST_WAIT_DER) || (state_q == mtns_pkg::ST_WAIT_CONV);

  mtns_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sc_req),
    .v_i    (sc_v),
    .m_i    (sc_m),
    .d_i    (sc_d),
    .rsp_o  (sc_rsp),
    .quot_o (sc_quot),
    .rem_o  (sc_rem)
  );

  // command sequencer
  always_comb begin
    state_d         = state_q;
    tick_total_d    = tick_total_q;
    last_ns_d       = last_ns_q;
    res_d           = res_q;
    mark_d          = mark_q;
    sc_req.start    = 1'b0;
    sc_req.skip_mul = 1'b0;
    sc_v            = opv_q;
    sc_m            = mtns_pkg::NsPerSec;
    sc_d            = rate;
    unique case (state_q)
      mtns_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = mtns_pkg::ST_ISSUE;
        end
      end
      mtns_pkg::ST_ISSUE: begin
        res_d  = '0;
        mark_d = 1'b0;
        state_d = mtns_pkg::ST_DONE;
        unique case (cmd_q)
          mtns_pkg::CMD_TICK: begin
            tick_total_d = tick_total_q + 1'b1;
            sc_v = tick_total_q + 1'b1;
            sc_d = tick_hz_w;
            sc_req.skip_mul = 1'b1;
            if (tick_hz_q != '0) begin
              sc_req.start = 1'b1;
              state_d = mtns_pkg::ST_WAIT_MARK;
            end
          end
          mtns_pkg::CMD_READ: begin
            if (enabled_q) begin
              if (counter_hz_q != '0) begin
                sc_v = cyc_q - cycle_base_q;
                sc_d = counter_hz_q;
                sc_req.start = 1'b1;
                state_d = mtns_pkg::ST_WAIT_NS;
              end else if (tick_hz_q != '0) begin
                sc_v = tick_total_q;
                sc_d = tick_hz_w;
                sc_req.start = 1'b1;
                state_d = mtns_pkg::ST_WAIT_NS;
              end else begin
                state_d = mtns_pkg::ST_CLAMP;
              end
            end
          end
          mtns_pkg::CMD_CYC2NS: begin
            if (rate != '0) begin
              sc_req.start = 1'b1;
              state_d = mtns_pkg::ST_WAIT_CONV;
            end
          end
          mtns_pkg::CMD_NS2CYC: begin
            sc_m = rate;
            sc_d = mtns_pkg::NsPerSec;
            if (rate != '0) begin
              sc_req.start = 1'b1;
              state_d = mtns_pkg::ST_WAIT_CONV;
            end
          end
          default: state_d = mtns_pkg::ST_DONE;
        endcase
      end
      mtns_pkg::ST_WAIT_MARK: begin
        if (sc_rsp.done) begin
          mark_d  = sc_rem == '0;
          state_d = mtns_pkg::ST_DONE;
        end
      end
      mtns_pkg::ST_WAIT_NS: begin
        if (sc_rsp.done) begin
          res_d   = sc_val;
          state_d = mtns_pkg::ST_CLAMP;
        end
      end
      mtns_pkg::ST_CLAMP: begin
        // never report less than before; then pull the tick count up to match
        res_d     = ns_c;
        last_ns_d = ns_c;
        sc_v      = ns_c;
        sc_m      = tick_hz_w;
        sc_d      = mtns_pkg::NsPerSec;
        if (tick_hz_q != '0) begin
          sc_req.start = 1'b1;
          state_d = mtns_pkg::ST_WAIT_DER;
        end else begin
          state_d = mtns_pkg::ST_DONE;
        end
      end
      mtns_pkg::ST_WAIT_DER: begin
        if (sc_rsp.done) begin
          if (sc_val > tick_total_q) begin
            tick_total_d = sc_val;
          end
          state_d = mtns_pkg::ST_DONE;
        end
      end
      mtns_pkg::ST_WAIT_CONV: begin
        if (sc_rsp.done) begin
          res_d   = sc_val;
          state_d = mtns_pkg::ST_DONE;
        end
      end
      mtns_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = mtns_pkg::ST_IDLE;
        end
      end
      default: state_d = mtns_pkg::ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mtns_pkg::ST_IDLE;
      tick_total_q <= '0;
      last_ns_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tick_total_q <= tick_total_d;
      last_ns_q    <= last_ns_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q    <= 1'b0;
      tick_hz_q    <= '0;
      counter_hz_q <= '0;
      cycle_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mtns_pkg::cfg_idx_e'(cfg_index_i))
        mtns_pkg::CFG_ENABLED:    enabled_q    <= cfg_data_i[0];
        mtns_pkg::CFG_TICK_HZ:    tick_hz_q    <= cfg_data_i[29:0];
        mtns_pkg::CFG_COUNTER_HZ: counter_hz_q <= cfg_data_i[mtns_pkg::RateW-1:0];
        mtns_pkg::CFG_CYCLE_BASE: cycle_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture, working result and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= mtns_pkg::cmd_e'(command_i);
      cyc_q <= cycle_count_i;
      opv_q <= operand_value_i;
    end
    res_q  <= res_d;
    mark_q <= mark_d;
    if (out_load) begin
      result_value_q <= res_q;
      tick_count_q   <= tick_total_q;
      second_mark_q  <= mark_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign tick_count_o   = tick_count_q;
  assign second_mark_o  = second_mark_q;

  // checks
  `MTNS_ASSERT_NEXT(a_busy_after_accept, in_acc, state_q != mtns_pkg::ST_IDLE)
  `MTNS_ASSERT_NEXT(a_last_ns_monotonic, 1'b1, last_ns_q >= $past(last_ns_q))
  `MTNS_ASSERT_NOW(a_done_when_waiting, sc_rsp.done, sc_wait)

endmodule

@@ verif/monotonic_timebase_ns_checker.sv @@
// checker for the nanosecond timebase: predicts each result and compares it
`timescale 1ns / 100ps
module monotonic_timebase_ns_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [63:0] cycle_count_i,
  input  logic [63:0] operand_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] result_value_i,
  input  logic [63:0] tick_count_i,
  input  logic        second_mark_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NsSec   = 64'd1000000000;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] ticks;
    logic        mark;
  } timebase_result_t;

  timebase_result_t expected_q[$];

  logic        en_q;
  logic [29:0] tick_hz_q;
  logic [33:0] counter_hz_q;
  logic [63:0] cycle_base_q;
  logic [63:0] ticks_q;
  logic [63:0] last_ns_q;

  // saturating floor(v * m / d)
  function automatic logic [63:0] scale_floor(logic [63:0] v, logic [63:0] m,
                                              logic [63:0] d);
    logic [127:0] hi;
    logic [127:0] lo;
    logic [127:0] sum;
    if (d == 0) return AllOnes;
    if (m == 0) return 64'd0;
    hi  = 128'(v / d) * 128'(m);
    lo  = (128'(v % d) * 128'(m)) / 128'(d);
    sum = hi + lo;
    if (sum > 128'(AllOnes)) return AllOnes;
    return sum[63:0];
  endfunction

  function automatic logic [63:0] conv_rate();
    return (counter_hz_q != 0) ? 64'(counter_hz_q) : 64'(tick_hz_q);
  endfunction

  // work out one result and advance the predicted state
  function automatic timebase_result_t predict_item(mtns_pkg::cmd_e cmd, logic [63:0] cyc,
                                                    logic [63:0] opv);
    timebase_result_t r;
    logic [63:0] ns;
    logic [63:0] rate;
    logic [63:0] derived;
    r = '0;
    case (cmd)
      mtns_pkg::CMD_TICK: begin
        ticks_q = ticks_q + 1;
        if (tick_hz_q != 0 && (ticks_q % 64'(tick_hz_q)) == 0) r.mark = 1'b1;
      end
      mtns_pkg::CMD_READ: begin
        if (en_q) begin
          if (counter_hz_q != 0) ns = scale_floor(cyc - cycle_base_q, NsSec,
                                                  64'(counter_hz_q));
          else if (tick_hz_q == 0) ns = 64'd0;
          else ns = scale_floor(ticks_q, NsSec, 64'(tick_hz_q));
          if (ns < last_ns_q) ns = last_ns_q;
          else last_ns_q = ns;
          if (tick_hz_q != 0) begin
            derived = scale_floor(ns, 64'(tick_hz_q), NsSec);
            if (derived > ticks_q) ticks_q = derived;
          end
          r.value = ns;
        end
      end
      mtns_pkg::CMD_CYC2NS: begin
        rate = conv_rate();
        r.value = (rate == 0) ? 64'd0 : scale_floor(opv, NsSec, rate);
      end
      default: begin
        rate = conv_rate();
        r.value = (rate == 0) ? 64'd0 : scale_floor(opv, rate, NsSec);
      end
    endcase
    r.ticks = ticks_q;
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // watch the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    timebase_result_t exp_r;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      en_q <= 0; tick_hz_q <= 0; counter_hz_q <= 0; cycle_base_q <= 0;
      ticks_q <= 0; last_ns_q <= 0; fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (mtns_pkg::cfg_idx_e'(cfg_index_i))
          mtns_pkg::CFG_ENABLED:    en_q = cfg_data_i[0];
          mtns_pkg::CFG_TICK_HZ:    tick_hz_q = cfg_data_i[29:0];
          mtns_pkg::CFG_COUNTER_HZ: counter_hz_q = cfg_data_i[33:0];
          default:                  cycle_base_q = cfg_data_i;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_item(mtns_pkg::cmd_e'(command_i), cycle_count_i,
                                          operand_value_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending");
          errs++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_value_i !== exp_r.value) begin
            $error("result_value expected %0d actual %0d", exp_r.value, result_value_i);
            errs++;
          end
          if (tick_count_i !== exp_r.ticks) begin
            $error("tick_count expected %0d actual %0d", exp_r.ticks, tick_count_i);
            errs++;
          end
          if (second_mark_i !== exp_r.mark) begin
            $error("second_mark expected %0d actual %0d", exp_r.mark, second_mark_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

@@ verif/monotonic_timebase_ns_tb.sv @@
// testbench top for the nanosecond timebase: stimulus, stalls and verdict
`timescale 1ns / 100ps
module monotonic_timebase_ns_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [63:0] cycle_count_i;
  logic [63:0] operand_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_value_o;
  logic [63:0] tick_count_o;
  logic        second_mark_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  int          fail_count;
  int          pending;
  bit          no_idle;
  bit          long_hold;

  monotonic_timebase_ns dut (.*);

  monotonic_timebase_ns_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i,
    .cycle_count_i, .operand_value_i, .out_valid_i(out_valid_o), .out_stall_i,
    .result_value_i(result_value_o), .tick_count_i(tick_count_o),
    .second_mark_i(second_mark_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #8000000;
    $display("monotonic_timebase_ns_tb NOT OK");
    $finish;
  end

  // receiver stalls: random bursts, one long hold-off
  initial begin
    int n;
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1;
        repeat (600) @(posedge clk_i);
        out_stall_i <= 0;
        long_hold = 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        out_stall_i <= 1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand biased toward edges
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 64'(0);
      1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      2: return 64'($urandom_range(0, 100000));
      3: return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  // valid stays high for the next write; set_rates drops it
  task automatic write_reg(mtns_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // valid stays high for a back-to-back item; an idle gap or drain drops it
  task automatic send_item(mtns_pkg::cmd_e cmd, logic [63:0] cyc, logic [63:0] opv);
    int n;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i      <= 1;
    command_i       <= cmd;
    cycle_count_i   <= cyc;
    operand_value_i <= opv;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait until all results are in, then the block's tail latency
  task automatic drain();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic set_rates(logic en, logic [63:0] thz, logic [63:0] chz,
                           logic [63:0] base);
    write_reg(mtns_pkg::CFG_ENABLED, 64'(en));
    write_reg(mtns_pkg::CFG_TICK_HZ, thz);
    write_reg(mtns_pkg::CFG_COUNTER_HZ, chz);
    write_reg(mtns_pkg::CFG_CYCLE_BASE, base);
    cfg_valid_i <= 0;
  endtask

  task automatic random_phase(int count);
    mtns_pkg::cmd_e cmd;
    for (int i = 0; i < count; i++) begin
      cmd = mtns_pkg::cmd_e'($urandom_range(0, 3));
      send_item(cmd, rand_operand(), rand_operand());
    end
  endtask

  initial begin
    logic [63:0] thz;
    logic [63:0] chz;
    rst_ni = 0;
    in_valid_i = 0; command_i = 0; cycle_count_i = 0; operand_value_i = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    no_idle = 0; long_hold = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: disabled, unknown rates
    send_item(mtns_pkg::CMD_READ, 64'd5, 64'd0);
    send_item(mtns_pkg::CMD_TICK, 64'd0, 64'd0);
    send_item(mtns_pkg::CMD_CYC2NS, 64'd0, 64'd1000);
    send_item(mtns_pkg::CMD_NS2CYC, 64'd0, '1);
    drain();
    // tick mode with small tick rate
    set_rates(1, 64'd3, 64'd0, 64'd0);
    repeat (4) send_item(mtns_pkg::CMD_TICK, 64'd0, 64'd0);
    send_item(mtns_pkg::CMD_READ, '1, 64'd0);
    send_item(mtns_pkg::CMD_CYC2NS, 64'd0, '1);
    send_item(mtns_pkg::CMD_NS2CYC, 64'd0, '1);
    drain();
    // counter mode, extremes, wrap below base
    set_rates(1, 64'd1000000000, 64'd10000000000, 64'd100);
    send_item(mtns_pkg::CMD_READ, 64'd50, 64'd0);
    send_item(mtns_pkg::CMD_READ, 64'd99, 64'd0);
    send_item(mtns_pkg::CMD_READ, 64'd200, 64'd0);
    send_item(mtns_pkg::CMD_CYC2NS, 64'd0, '1);
    send_item(mtns_pkg::CMD_NS2CYC, 64'd0, '1);
    send_item(mtns_pkg::CMD_TICK, 64'd0, 64'd0);
    drain();
    set_rates(1, 64'd0, 64'd1, '1);
    send_item(mtns_pkg::CMD_READ, 64'd0, 64'd0);
    send_item(mtns_pkg::CMD_READ, 64'd5, 64'd0);
    send_item(mtns_pkg::CMD_CYC2NS, 64'd0, '1);
    send_item(mtns_pkg::CMD_NS2CYC, 64'd0, 64'd999999999);
    drain();

    // random phases with varied settings
    for (int p = 0; p < 11; p++) begin
      case ($urandom_range(0, 3))
        0: thz = 64'd0;
        1: thz = 64'd1000000000;
        2: thz = 64'($urandom_range(1, 20));
        default: thz = 64'($urandom_range(1, 1000000000));
      endcase
      case ($urandom_range(0, 3))
        0: chz = 64'd0;
        1: chz = 64'd10000000000;
        2: chz = 64'($urandom_range(1, 1000));
        default: chz = {30'd0, 2'($urandom()), $urandom()};
      endcase
      set_rates(p % 5 != 0, thz, chz, rand_operand());
      if (p == 3) long_hold = 1;
      if (p == 10) no_idle = 1;
      random_phase(148);
      drain();
    end

    if (fail_count == 0) begin
      $display("monotonic_timebase_ns_tb OK");
    end else begin
      $display("monotonic_timebase_ns_tb NOT OK");
    end
    $finish;
  end
endmodule
